// File: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Holds the phase, kind and error codes, the character constants and the
// result record types passed between the step logic and the result buffer.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int MAX_RES = 3;
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERR   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NO_QUOTE  = 3'd0,
    ERR_CTRL      = 3'd1,
    ERR_ESC_EOI   = 3'd2,
    ERR_BAD_ESC   = 3'd3,
    ERR_HEX_EOI   = 3'd4,
    ERR_BAD_HEX   = 3'd5,
    ERR_SURROGATE = 3'd6,
    ERR_UNTERM    = 3'd7
  } err_t;

  // Characters that steer decoding
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [15:0] SURR_LO   = 16'hd800;
  localparam logic [15:0] SURR_HI   = 16'hdfff;
  localparam logic [15:0] UTF8_MAX1 = 16'h007f;
  localparam logic [15:0] UTF8_MAX2 = 16'h07ff;
  localparam logic [7:0]  UTF8_LEAD2 = 8'hc0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'he0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    err_t       code;
    logic       last;
  } res_t;

  // res[0] is delivered first
  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [CNT_W-1:0]   cnt;
  } step_res_t;

endpackage

// File: rtl/jsu_step.sv
// ----------------------------------------------------------------------------
// jsu_step: per-byte decode logic
// Maps the current phase, the gathered hex digits and one input byte to the
// next phase and to the zero to three result records that the byte causes.
// ----------------------------------------------------------------------------
module jsu_step import jsu_pkg::*; (
  input  phase_t      phase_i,
  input  logic [11:0] hex_val_i,
  input  logic [1:0]  hex_cnt_i,
  input  logic [7:0]  byte_i,
  input  logic        eoi_i,
  output phase_t      phase_o,
  output logic [11:0] hex_val_o,
  output logic [1:0]  hex_cnt_o,
  output step_res_t   res_o
);

  logic [3:0]  digit;
  logic        digit_ok;
  logic [15:0] cp;

  // hex digit, either case
  always_comb begin
    digit    = 4'd0;
    digit_ok = 1'b1;
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      digit = byte_i[3:0];
    end else if ((byte_i >= 8'h61 && byte_i <= 8'h66) ||
                 (byte_i >= 8'h41 && byte_i <= 8'h46)) begin
      digit = byte_i[3:0] + 4'd9;
    end else begin
      digit_ok = 1'b0;
    end
  end

  assign cp = {hex_val_i, digit};

  always_comb begin
    phase_o   = phase_i;
    hex_val_o = hex_val_i;
    hex_cnt_o = hex_cnt_i;
    res_o     = '0;

    unique case (phase_i)
      PH_BODY: begin
        res_o.cnt = CNT_W'(1);
        res_o.res[0].last = 1'b1;
        if (eoi_i) begin
          phase_o = PH_IDLE;
          res_o.res[0].kind = KIND_ERR;
          res_o.res[0].code = ERR_UNTERM;
        end else if (byte_i == CH_QUOTE) begin
          phase_o = PH_IDLE;
          res_o.res[0].kind = KIND_CLOSE;
        end else if (byte_i < CH_SPACE) begin
          phase_o = PH_IDLE;
          res_o.res[0].kind = KIND_ERR;
          res_o.res[0].code = ERR_CTRL;
        end else if (byte_i == CH_BSLASH) begin
          phase_o   = PH_ESC;
          res_o.cnt = '0;
        end else begin
          res_o.res[0].data = byte_i;
        end
      end

      PH_ESC: begin
        res_o.cnt = CNT_W'(1);
        res_o.res[0].last = 1'b1;
        phase_o = PH_BODY;
        if (eoi_i) begin
          phase_o = PH_IDLE;
          res_o.res[0].kind = KIND_ERR;
          res_o.res[0].code = ERR_ESC_EOI;
        end else begin
          unique case (byte_i)
            CH_QUOTE:  res_o.res[0].data = CH_QUOTE;
            CH_BSLASH: res_o.res[0].data = CH_BSLASH;
            CH_SLASH:  res_o.res[0].data = CH_SLASH;
            CH_B:      res_o.res[0].data = CH_BS;
            CH_F:      res_o.res[0].data = CH_FF;
            CH_N:      res_o.res[0].data = CH_LF;
            CH_R:      res_o.res[0].data = CH_CR;
            CH_T:      res_o.res[0].data = CH_TAB;
            CH_U: begin
              phase_o   = PH_HEX;
              hex_val_o = '0;
              hex_cnt_o = '0;
              res_o.cnt = '0;
            end
            default: begin
              phase_o = PH_IDLE;
              res_o.res[0].kind = KIND_ERR;
              res_o.res[0].code = ERR_BAD_ESC;
            end
          endcase
        end
      end

      PH_HEX: begin
        if (eoi_i || !digit_ok) begin
          phase_o = PH_IDLE;
          res_o.cnt = CNT_W'(1);
          res_o.res[0].last = 1'b1;
          res_o.res[0].kind = KIND_ERR;
          res_o.res[0].code = eoi_i ? ERR_HEX_EOI : ERR_BAD_HEX;
        end else if (hex_cnt_i != 2'd3) begin
          hex_val_o = {hex_val_i[7:0], digit};
          hex_cnt_o = hex_cnt_i + 2'd1;
        end else if (cp >= SURR_LO && cp <= SURR_HI) begin
          phase_o = PH_IDLE;
          res_o.cnt = CNT_W'(1);
          res_o.res[0].last = 1'b1;
          res_o.res[0].kind = KIND_ERR;
          res_o.res[0].code = ERR_SURROGATE;
        end else begin
          phase_o = PH_BODY;
          if (cp <= UTF8_MAX1) begin
            res_o.cnt = CNT_W'(1);
            res_o.res[0].data = cp[7:0];
            res_o.res[0].last = 1'b1;
          end else if (cp <= UTF8_MAX2) begin
            res_o.cnt = CNT_W'(2);
            res_o.res[0].data = UTF8_LEAD2 | {3'b000, cp[10:6]};
            res_o.res[1].data = UTF8_CONT | {2'b00, cp[5:0]};
            res_o.res[1].last = 1'b1;
          end else begin
            res_o.cnt = CNT_W'(3);
            res_o.res[0].data = UTF8_LEAD3 | {4'b0000, cp[15:12]};
            res_o.res[1].data = UTF8_CONT | {2'b00, cp[11:6]};
            res_o.res[2].data = UTF8_CONT | {2'b00, cp[5:0]};
            res_o.res[2].last = 1'b1;
          end
        end
        if (phase_o != PH_HEX) begin
          hex_val_o = '0;
          hex_cnt_o = '0;
        end
      end

      default: begin
        hex_val_o = '0;
        hex_cnt_o = '0;
        if (eoi_i || byte_i != CH_QUOTE) begin
          res_o.cnt = CNT_W'(1);
          res_o.res[0].last = 1'b1;
          res_o.res[0].kind = KIND_ERR;
          res_o.res[0].code = ERR_NO_QUOTE;
        end else begin
          phase_o = PH_BODY;
        end
      end
    endcase
  end

endmodule

// File: rtl/jsu_out_buf.sv
// ----------------------------------------------------------------------------
// jsu_out_buf: result register with room for one byte's results
// Loads up to three result records at once and hands them out one per
// transfer, oldest first.
// ----------------------------------------------------------------------------
module jsu_out_buf import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load_i,
  input  step_res_t load_res_i,
  output logic      room_o,
  output logic      out_tvalid,
  input  logic      out_tready,
  output res_t      head_o
);

  res_t [MAX_RES-1:0] ent_r;
  res_t [MAX_RES-1:0] ent_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic               take;

  assign take       = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != '0);
  assign head_o     = ent_r[0];
  // free once the last pending record leaves in this cycle
  assign room_o     = (cnt_r == '0) || (cnt_r == CNT_W'(1) && out_tready);

  always_comb begin
    ent_nxt = ent_r;
    cnt_nxt = cnt_r;
    if (load_i) begin
      ent_nxt = load_res_i.res;
      cnt_nxt = load_res_i.cnt;
    end else if (take) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        ent_nxt[i] = ent_r[i+1];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    load_i |-> room_o)
    else $error("result buffer loaded while still holding records");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RES))
    else $error("result count beyond capacity");

  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CNT_W'(1)) |-> ent_r[0].last)
    else $error("final pending record not marked last");

  a_no_early_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r > CNT_W'(1)) |-> !ent_r[0].last)
    else $error("record marked last while more are pending");

endmodule

// File: rtl/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: JSON string literal to UTF-8 bytes
// Decodes a quoted string literal byte by byte, expanding escapes and
// \uXXXX sequences, and reports close and error events in-band.
// ----------------------------------------------------------------------------
// Usage:
//   Input transfers carry one literal byte in in_tdata, starting with the
//   opening quote; in_tuser set means the input ran out (tdata ignored).
//   Each output transfer carries one result: a content byte, a close
//   marker or an error code, with out_tlast on the final result that one
//   input byte causes. Escape backslashes and hex digits cause no result
//   until the sequence completes; a \uXXXX escape yields one to three bytes.
//   An input byte passes the input register, then the result register, before
//   its first result appears. Throughput: one input byte per cycle while the
//   receiver takes every result and each byte causes at most one result; a
//   byte with several results holds the result register until all have left.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   decoder to idle, waiting for an opening quote.
//   When the receiver stalls, the pending result holds on out_tdata; one
//   more input byte waits in the input register, then in_tready drops.
//   After a close or any error the decoder is idle again.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  input  logic        in_tuser,    // [0] end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] out_byte, [10:8] error_code
  output logic [1:0]  out_tuser,   // [1:0] kind
  output logic        out_tlast    // final result of one input byte
);

  // Input register
  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic        in_eoi_r;

  // Decoder state
  phase_t      phase_r;
  phase_t      phase_nxt;
  logic [11:0] hex_val_r;
  logic [11:0] hex_val_nxt;
  logic [1:0]  hex_cnt_r;
  logic [1:0]  hex_cnt_nxt;

  step_res_t   step_res;
  res_t        head;
  logic        room;
  logic        adv;
  logic        in_take;

  // Advance the held byte once the result register can take its results
  assign adv       = in_vld_r && room;
  assign in_tready = !in_vld_r || adv;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_tdata;
      in_eoi_r  <= in_tuser;
    end
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  jsu_step u_step (
    .phase_i   (phase_r),
    .hex_val_i (hex_val_r),
    .hex_cnt_i (hex_cnt_r),
    .byte_i    (in_byte_r),
    .eoi_i     (in_eoi_r),
    .phase_o   (phase_nxt),
    .hex_val_o (hex_val_nxt),
    .hex_cnt_o (hex_cnt_nxt),
    .res_o     (step_res)
  );

  // Commit the state update together with the results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      hex_val_r <= '0;
      hex_cnt_r <= '0;
    end else if (adv) begin
      phase_r   <= phase_nxt;
      hex_val_r <= hex_val_nxt;
      hex_cnt_r <= hex_cnt_nxt;
    end
  end

  jsu_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (adv),
    .load_res_i (step_res),
    .room_o     (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .head_o     (head)
  );

  assign out_tdata = {5'b00000, head.code, head.data};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

  a_hex_cnt_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (hex_cnt_r != 2'd0) |-> (phase_r == PH_HEX))
    else $error("hex digits gathered outside a unicode escape");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !adv) |=> (in_vld_r && $stable(in_byte_r) && $stable(in_eoi_r)))
    else $error("held input byte lost or changed");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(adv) && $past(rst_n) |-> $stable(phase_r))
    else $error("phase changed without an advancing byte");

endmodule
